[hdl/ucwt_pkg.sv]
// ----------------------------------------------------------------------------
// ucwt_pkg
// Shared types and constants of the UTF-8 Cyrillic word tokenizer.
// ----------------------------------------------------------------------------
package ucwt_pkg;

    // Input beat: one request byte plus the end flag
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_request;
    } t_in_item;

    // Output beat: one word byte or one word-end marker
    typedef struct packed {
        logic [7:0] word_byte;
        logic       kind;
        logic       last;
    } t_out_item;

    // Most results one input byte can cause
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Results of one byte, handed from the decoder to the output buffer
    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        t_out_item [MAX_RESULTS-1:0]       items;
    } t_dec_res;

    // Token class of the previous byte
    localparam logic [1:0] TOK_NONE  = 2'd0;
    localparam logic [1:0] TOK_WORD  = 2'd1;
    localparam logic [1:0] TOK_PUNCT = 2'd2;

    // Result kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Byte constants
    localparam logic [7:0] LEAD_D0    = 8'hD0;
    localparam logic [7:0] LEAD_D1    = 8'hD1;
    localparam logic [7:0] CASE_SHIFT = 8'd32;

endpackage

[hdl/utf8_cyrillic_word_tokenizer_unit.sv]
// ----------------------------------------------------------------------------
// utf8_cyrillic_word_tokenizer_unit
// Streams lowercased word bytes and word-end markers from UTF-8 request text.
// ----------------------------------------------------------------------------
//  channel | direction | payload                          | handshake
//  in      | input     | in_byte, end_of_request          | i_in_valid / o_in_ready
//  out     | output    | word_byte, kind, last            | o_out_valid / i_out_ready
//
//  A byte is decoded in the cycle it is accepted; its results (0 to 3) appear
//  from the next cycle on, one beat per cycle while i_out_ready is high, from a
//  three-entry result register. One byte per cycle while each byte yields at most
//  one result and no output stall; more results hold input until the last one leaves.
//  Synchronous active-low reset clears the token state and the result count.
//  An output stall stops input intake whenever a beat is still pending.
// ----------------------------------------------------------------------------
module utf8_cyrillic_word_tokenizer_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ucwt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ucwt_pkg::t_out_item o_out_data
);
    import ucwt_pkg::*;

    logic     accept;
    logic     can_load;
    t_dec_res dec_res;

    assign o_in_ready = can_load;
    assign accept     = i_in_valid && can_load;

    ucwt_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_res    (dec_res)
    );

    ucwt_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_res      (dec_res),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

    // A byte with results shows its first result on the next cycle
    a_first_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (dec_res.count != '0) |=>
            o_out_valid && (o_out_data == $past(dec_res.items[0])))
        else $error("first result of a byte not presented");

    // No new byte while the current one still has results behind this beat
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> !o_in_ready)
        else $error("input accepted before results of previous byte drained");

    // A non-final beat is always followed by another result
    a_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last |=> o_out_valid)
        else $error("result sequence ended without last flag");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

[hdl/ucwt_decode.sv]
// ----------------------------------------------------------------------------
// ucwt_decode
// Classifies one byte against the tokenizer state and produces up to three
// results; the state registers advance on each accepted beat.
// ----------------------------------------------------------------------------
module ucwt_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ucwt_pkg::t_in_item i_item,
    output ucwt_pkg::t_dec_res o_res
);
    import ucwt_pkg::*;

    logic [1:0] r_tok, n_tok;
    logic       r_lead, n_lead;
    logic       r_d1, n_d1;

    logic [7:0] b;
    logic       is_cont, is_alpha, is_punct, is_lead, do_class;
    logic [CNT_W-1:0] cnt;
    t_out_item [MAX_RESULTS-1:0] items;
    t_out_item end_item;

    assign b        = i_item.in_byte;
    assign is_cont  = b inside {[8'h80:8'hBF]};
    assign is_alpha = b inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    assign is_punct = b inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
    assign is_lead  = (b == LEAD_D0) || (b == LEAD_D1);
    assign end_item = '{word_byte: 8'h00, kind: KIND_END, last: 1'b0};

    // Next state and result list
    always_comb begin
        n_tok    = r_tok;
        n_lead   = r_lead;
        n_d1     = r_d1;
        cnt      = '0;
        items    = '0;
        do_class = 1'b0;

        if (r_lead) begin
            n_lead = 1'b0;
            if (is_cont) begin
                n_tok = TOK_WORD;
                cnt   = CNT_W'(2);
                if (b inside {[8'h90:8'h9F]}) begin
                    items[0] = '{word_byte: LEAD_D0, kind: KIND_BYTE, last: 1'b0};
                    items[1] = '{word_byte: b + CASE_SHIFT, kind: KIND_BYTE, last: 1'b0};
                end else if (b inside {[8'hA0:8'hAF]}) begin
                    items[0] = '{word_byte: LEAD_D1, kind: KIND_BYTE, last: 1'b0};
                    items[1] = '{word_byte: b - CASE_SHIFT, kind: KIND_BYTE, last: 1'b0};
                end else begin
                    items[0] = '{word_byte: (r_d1 ? LEAD_D1 : LEAD_D0),
                                 kind: KIND_BYTE, last: 1'b0};
                    items[1] = '{word_byte: b, kind: KIND_BYTE, last: 1'b0};
                end
            end else begin
                do_class = 1'b1;
            end
        end else if (is_lead) begin
            n_lead = 1'b1;
            n_d1   = (b == LEAD_D1);
        end else begin
            do_class = 1'b1;
        end

        // ASCII rules; nothing has been emitted yet on this path
        if (do_class) begin
            if (is_alpha) begin
                n_tok    = TOK_WORD;
                cnt      = CNT_W'(1);
                items[0] = '{word_byte: (b <= 8'h5A) ? b + CASE_SHIFT : b,
                             kind: KIND_BYTE, last: 1'b0};
            end else begin
                if (r_tok == TOK_WORD) begin
                    cnt      = CNT_W'(1);
                    items[0] = end_item;
                end
                n_tok = is_punct ? TOK_PUNCT : TOK_NONE;
            end
        end

        // End of request: close an open word, drop any held lead
        if (i_item.end_of_request) begin
            if (n_tok == TOK_WORD) begin
                case (cnt)
                    CNT_W'(0): items[0] = end_item;
                    CNT_W'(1): items[1] = end_item;
                    default:   items[2] = end_item;
                endcase
                cnt = cnt + CNT_W'(1);
            end
            n_tok  = TOK_NONE;
            n_lead = 1'b0;
            n_d1   = 1'b0;
        end

        // Flag the final result of this byte
        case (cnt)
            CNT_W'(1): items[0].last = 1'b1;
            CNT_W'(2): items[1].last = 1'b1;
            CNT_W'(3): items[2].last = 1'b1;
            default:   ;
        endcase
    end

    assign o_res.count = cnt;
    assign o_res.items = items;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= TOK_NONE;
            r_lead <= 1'b0;
            r_d1   <= 1'b0;
        end else if (i_accept) begin
            r_tok  <= n_tok;
            r_lead <= n_lead;
            r_d1   <= n_d1;
        end
    end

endmodule

[hdl/ucwt_out_buf.sv]
// ----------------------------------------------------------------------------
// ucwt_out_buf
// Result register of up to three entries; loads the results of one byte and
// shifts them out one beat at a time.
// ----------------------------------------------------------------------------
module ucwt_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  ucwt_pkg::t_dec_res  i_res,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_ready,
    output ucwt_pkg::t_out_item o_data
);
    import ucwt_pkg::*;

    t_out_item [MAX_RESULTS-1:0] r_buf, n_buf;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        pop;

    assign o_valid    = (r_cnt != '0);
    assign o_data     = r_buf[0];
    assign pop        = o_valid && i_ready;
    // Free now, or the last entry leaves this cycle
    assign o_can_load = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_ready);

    // Load or shift
    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        if (i_load) begin
            n_buf = i_res.items;
            n_cnt = i_res.count;
        end else if (pop) begin
            n_buf[0] = r_buf[1];
            n_buf[1] = r_buf[2];
            n_cnt    = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

[test/ucwt_stream_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ucwt_stream_checker
// Watches both channels of the word tokenizer, predicts the word bytes and
// word-end markers of every accepted request byte and compares each output
// beat, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module ucwt_stream_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  ucwt_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  ucwt_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_beats_owed
);
    import ucwt_pkg::*;

    // Tokenizer state as the predictor sees it
    logic [1:0] tok_class;
    logic       lead_held;
    logic       lead_hi;

    // Beats of the byte being predicted, then the queue of all owed beats
    t_out_item  byte_beats [MAX_RESULTS];
    int         byte_beat_cnt;
    t_out_item  owed_beats [$];

    initial begin
        o_fail_count = 0;
        o_beats_owed = 0;
    end

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
               (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
    endfunction

    task add_beat(input logic [7:0] b, input logic k);
        t_out_item beat;
        beat.word_byte = b;
        beat.kind      = k;
        beat.last      = 1'b0;
        byte_beats[byte_beat_cnt] = beat;
        byte_beat_cnt++;
    endtask

    // ASCII rules: letters join the word, anything else closes it
    task classify_ascii(input logic [7:0] b);
        if (is_letter(b)) begin
            tok_class = TOK_WORD;
            add_beat((b <= 8'h5A) ? b + CASE_SHIFT : b, KIND_BYTE);
        end else begin
            if (tok_class == TOK_WORD)
                add_beat(8'h00, KIND_END);
            tok_class = is_punct(b) ? TOK_PUNCT : TOK_NONE;
        end
    endtask

    task predict_beats(input t_in_item item);
        logic [7:0] b;
        b = item.in_byte;
        byte_beat_cnt = 0;
        if (lead_held) begin
            lead_held = 1'b0;
            if (b >= 8'h80 && b <= 8'hBF) begin
                // Cyrillic letter; only the upper-case ranges get folded
                tok_class = TOK_WORD;
                if (b >= 8'h90 && b <= 8'h9F) begin
                    add_beat(LEAD_D0, KIND_BYTE);
                    add_beat(b + CASE_SHIFT, KIND_BYTE);
                end else if (b >= 8'hA0 && b <= 8'hAF) begin
                    add_beat(LEAD_D1, KIND_BYTE);
                    add_beat(b - CASE_SHIFT, KIND_BYTE);
                end else begin
                    add_beat(lead_hi ? LEAD_D1 : LEAD_D0, KIND_BYTE);
                    add_beat(b, KIND_BYTE);
                end
            end else begin
                // lead dropped; a second lead here is just a separator
                classify_ascii(b);
            end
        end else if (b == LEAD_D0 || b == LEAD_D1) begin
            lead_held = 1'b1;
            lead_hi   = (b == LEAD_D1);
        end else begin
            classify_ascii(b);
        end

        // end of request: close the word, drop any held lead
        if (item.end_of_request) begin
            if (tok_class == TOK_WORD)
                add_beat(8'h00, KIND_END);
            tok_class = TOK_NONE;
            lead_held = 1'b0;
            lead_hi   = 1'b0;
        end

        if (byte_beat_cnt > 0)
            byte_beats[byte_beat_cnt-1].last = 1'b1;
        for (int i = 0; i < byte_beat_cnt; i++)
            owed_beats.insert(owed_beats.size(), byte_beats[i]);
    endtask

    // Output beats are checked first: a byte accepted at this edge
    // cannot have produced anything yet.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            tok_class = TOK_NONE;
            lead_held = 1'b0;
            lead_hi   = 1'b0;
            owed_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_beats.size() == 0) begin
                    $display("%0t: unexpected beat, actual %02h kind %0b last %0b",
                             $time, i_out_data.word_byte, i_out_data.kind,
                             i_out_data.last);
                    o_fail_count++;
                end else begin
                    want = owed_beats.pop_front();
                    if (i_out_data.word_byte !== want.word_byte) begin
                        $display("%0t: word_byte mismatch, expected %02h, actual %02h",
                                 $time, want.word_byte, i_out_data.word_byte);
                        o_fail_count++;
                    end
                    if (i_out_data.kind !== want.kind) begin
                        $display("%0t: kind mismatch, expected %0b, actual %0b",
                                 $time, want.kind, i_out_data.kind);
                        o_fail_count++;
                    end
                    if (i_out_data.last !== want.last) begin
                        $display("%0t: last mismatch, expected %0b, actual %0b",
                                 $time, want.last, i_out_data.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_beats(i_in_data);
        end
        o_beats_owed <= owed_beats.size();
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the word tokenizer: a directed pass over letter
// ranges, punctuation, separators and Cyrillic lead handling, then random
// words of ASCII and Cyrillic letters mixed with noise, with random gaps on
// the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
    import ucwt_pkg::*;

    localparam int TOTAL_ITEMS = 100;
    localparam int CYCLE_LIMIT = 200000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    int        fail_count;
    int        beats_owed;
    int        cycle_count = 0;
    int        sent_items  = 0;
    bit        no_gaps     = 1'b0;

    utf8_cyrillic_word_tokenizer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    ucwt_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_beats_owed (beats_owed)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Request side: random gap, then hold the beat until it is taken
    task send_byte(input logic [7:0] b, input logic eor);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid               <= 1'b1;
        i_in_data.in_byte        <= b;
        i_in_data.end_of_request <= eor;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_items++;
    endtask

    // Hold off new bytes until every owed beat has been seen
    task drain_owed_beats;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (beats_owed != 0);
    endtask

    function automatic logic [7:0] pick_letter;
        return $urandom_range(1) ? 8'($urandom_range(8'h5A, 8'h41))
                                 : 8'($urandom_range(8'h7A, 8'h61));
    endfunction

    function automatic logic [7:0] pick_punct;
        case ($urandom_range(3))
            0:       return 8'($urandom_range(8'h2F, 8'h21));
            1:       return 8'($urandom_range(8'h40, 8'h3A));
            2:       return 8'($urandom_range(8'h60, 8'h5B));
            default: return 8'($urandom_range(8'h7E, 8'h7B));
        endcase
    endfunction

    function automatic logic [7:0] pick_separator;
        case ($urandom_range(3))
            0:       return 8'h20;
            1:       return 8'($urandom_range(8'h39, 8'h30));
            2:       return 8'($urandom_range(8'h1F, 8'h00));
            default: return 8'($urandom_range(8'hFF, 8'hC0));
        endcase
    endfunction

    // Result side: random stall before each beat
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(4);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        int          word_len;
        logic        eor_last;
        logic        eor;
        logic [7:0]  cont;
        bit          drained_mid;

        drained_mid = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        @(posedge i_clk);

        // Directed: letter bounds, punctuation, separators, lead handling
        send_byte(8'h41, 1'b0);    // 'A' folds to 'a'
        send_byte(8'h7A, 1'b0);    // 'z'
        send_byte(8'h21, 1'b0);    // '!' closes the word
        send_byte(8'h5A, 1'b0);    // 'Z'
        send_byte(8'h7E, 1'b0);    // '~'
        send_byte(8'h61, 1'b0);    // 'a'
        send_byte(LEAD_D0, 1'b0);
        send_byte(8'h90, 1'b0);    // upper range of D0 folds up
        send_byte(LEAD_D1, 1'b0);
        send_byte(8'hAF, 1'b0);    // upper range of D1 folds down
        send_byte(LEAD_D1, 1'b0);
        send_byte(8'hBF, 1'b0);    // lower-case letter passes with its lead
        send_byte(LEAD_D0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(LEAD_D0, 1'b0);
        send_byte(LEAD_D1, 1'b0);  // second lead after a lead is a separator
        send_byte(LEAD_D1, 1'b0);
        send_byte(8'h41, 1'b0);    // lead dropped, byte taken as ASCII
        send_byte(8'h30, 1'b0);    // digit separates
        send_byte(8'h5B, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h71, 1'b0);
        send_byte(LEAD_D0, 1'b0);
        send_byte(8'h9F, 1'b1);    // letter plus flush: three beats
        send_byte(LEAD_D0, 1'b1);  // held lead dropped at the end
        send_byte(8'h00, 1'b1);
        drain_owed_beats();

        // Random: mostly words, the rest noise and broken leads
        while (sent_items < TOTAL_ITEMS) begin
            if ($urandom_range(7) == 0)
                no_gaps = !no_gaps;
            if (!drained_mid && sent_items >= TOTAL_ITEMS / 2) begin
                drained_mid = 1'b1;
                drain_owed_beats();
            end
            if ($urandom_range(99) < 75) begin
                word_len = $urandom_range(5, 1);
                eor_last = ($urandom_range(7) == 0);
                for (int k = 0; k < word_len; k++) begin
                    eor = eor_last && (k == word_len - 1);
                    if ($urandom_range(1)) begin
                        send_byte(pick_letter(), eor);
                    end else begin
                        send_byte($urandom_range(1) ? LEAD_D1 : LEAD_D0, 1'b0);
                        cont = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                        : 8'($urandom_range(8'hBF, 8'h80));
                        send_byte(cont, eor);
                    end
                end
                case ($urandom_range(3))
                    0:       send_byte(pick_punct(), 1'b0);
                    1:       send_byte(pick_separator(), 1'b0);
                    2:       send_byte(pick_separator(), 1'b1);
                    default: ;
                endcase
            end else begin
                send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
            end
        end

        // Drain and settle, then verdict
        no_gaps = 1'b0;
        drain_owed_beats();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
